// File: src/tplc_pkg.sv
`timescale 1ns / 1ps

package tplc_pkg;

  localparam int unsigned EV_W = 11;

  localparam int unsigned EV_UPPER_SET = 0;
  localparam int unsigned EV_UPPER_CLR = 1;
  localparam int unsigned EV_STORE_SET = 2;
  localparam int unsigned EV_STORE_CLR = 3;
  localparam int unsigned EV_DISABLED  = 4;
  localparam int unsigned EV_DRY       = 5;
  localparam int unsigned EV_CYCLING   = 6;
  localparam int unsigned EV_FULL      = 7;
  localparam int unsigned EV_NO_WATER  = 8;
  localparam int unsigned EV_REFILLED  = 9;
  localparam int unsigned EV_SETTLE    = 10;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_POLL   = 3'd0,
    CFG_FAST_POLL     = 3'd1,
    CFG_DRY_RUN_LIMIT = 3'd2,
    CFG_DRY_HOLD      = 3'd3,
    CFG_SHORT_RUN     = 3'd4,
    CFG_CYCLING_HOLD  = 3'd5,
    CFG_REFILL_SETTLE = 3'd6
  } cfg_index_t;

  localparam logic [9:0]  MS_PER_S = 10'd1000;
  localparam logic [31:0] DELAY_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  normal_poll_seconds;
    logic [7:0]  fast_poll_seconds;
    logic [31:0] dry_run_limit_ms;
    logic [31:0] dry_hold_ms;
    logic [31:0] short_run_ms;
    logic [31:0] cycling_hold_ms;
    logic [31:0] refill_settle_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    normal_poll_seconds: 8'd120,
    fast_poll_seconds:   8'd1,
    dry_run_limit_ms:    32'd60000,
    dry_hold_ms:         32'd14400000,
    short_run_ms:        32'd5000,
    cycling_hold_ms:     32'd14400000,
    refill_settle_ms:    32'd60000
  };

  typedef struct packed {
    logic        upper_full_n;
    logic        upper_empty;
    logic        store_full;
    logic        store_empty;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic            pump_drive;
    logic [3:0]      lamp_bits;
    logic            upper_fault;
    logic            store_fault;
    logic [EV_W-1:0] event_bits;
    logic [31:0]     next_poll_ms;
    logic [31:0]     run_total_ms;
    logic [31:0]     drain_ms;
  } result_t;

endpackage

// File: src/tplc_if.sv
`timescale 1ns / 1ps

interface tplc_poll_if;
  logic        valid;
  logic        ready;
  logic        upper_full_n;
  logic        upper_empty;
  logic        store_full;
  logic        store_empty;
  logic [31:0] now_ms;

  modport source (output valid, upper_full_n, upper_empty, store_full, store_empty, now_ms,
                  input ready);
  modport sink (input valid, upper_full_n, upper_empty, store_full, store_empty, now_ms,
                output ready);
endinterface

interface tplc_result_if;
  logic                       valid;
  logic                       ready;
  logic                       pump_drive;
  logic [3:0]                 lamp_bits;
  logic                       upper_fault;
  logic                       store_fault;
  logic [tplc_pkg::EV_W-1:0]  event_bits;
  logic [31:0]                next_poll_ms;
  logic [31:0]                run_total_ms;
  logic [31:0]                drain_ms;

  modport source (output valid, pump_drive, lamp_bits, upper_fault, store_fault, event_bits,
                         next_poll_ms, run_total_ms, drain_ms,
                  input ready);
  modport sink (input valid, pump_drive, lamp_bits, upper_fault, store_fault, event_bits,
                      next_poll_ms, run_total_ms, drain_ms,
                output ready);
endinterface

interface tplc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tplc_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/tplc_core.sv
`timescale 1ns / 1ps

module tplc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tplc_pkg::poll_t   item,
  input  tplc_pkg::cfg_t    cfg,
  output tplc_pkg::result_t res
);

  logic                      last_store_empty;
  logic                      upper_fault_flag;
  logic                      store_fault_flag;
  logic                      pump_running;
  logic [3:0]                lamps;
  logic [31:0]               run_start_time;
  logic [31:0]               run_time_sum;
  logic [31:0]               cycle_hold;
  logic [31:0]               drain_start_time;
  logic [31:0]               drain_time;

  logic                      pump_running_next;
  logic [3:0]                lamps_next;
  logic [31:0]               run_start_time_next;
  logic [31:0]               run_time_sum_next;
  logic [31:0]               cycle_hold_next;
  logic [31:0]               drain_start_time_next;
  logic [31:0]               drain_time_next;
  logic                      upper_fault_next;
  logic                      store_fault_next;

  logic                      pump_path;
  logic                      dry_stop;
  logic                      start;
  logic                      settle;
  logic                      real_stop;
  logic                      cycling;
  logic [31:0]               run_len;
  logic [31:0]               extra_hold;
  logic [7:0]                poll_s;
  logic [17:0]               poll_ms;
  logic [33:0]               delay;
  logic [tplc_pkg::EV_W-1:0] ev;

  always_comb begin
    upper_fault_next = !item.upper_full_n && item.upper_empty;
    store_fault_next = item.store_full && item.store_empty;

    run_len   = item.now_ms - run_start_time;
    pump_path = item.upper_full_n && item.upper_empty;
    // a store fault blocks the dry check, but that poll stops the pump anyway
    dry_stop  = pump_running && pump_path && !store_fault_next
                && (run_len > cfg.dry_run_limit_ms);
    start     = !pump_running && pump_path && !item.store_empty;
    settle    = start && last_store_empty;
    real_stop = pump_running && (!item.upper_full_n || item.store_empty || dry_stop);
    cycling   = real_stop && (run_len < cfg.short_run_ms);

    pump_running_next = start ? 1'b1 : (real_stop ? 1'b0 : pump_running);

    if (start) begin
      run_start_time_next = item.now_ms + (settle ? cfg.refill_settle_ms : 32'd0);
    end else if (real_stop) begin
      run_start_time_next = '0;
    end else begin
      run_start_time_next = run_start_time;
    end

    run_time_sum_next     = real_stop ? run_time_sum + run_len : run_time_sum;
    drain_start_time_next = real_stop ? item.now_ms : drain_start_time;

    if (!real_stop) begin
      cycle_hold_next = cycle_hold;
    end else if (cycling) begin
      cycle_hold_next = cfg.cycling_hold_ms;
    end else if (cycle_hold == cfg.cycling_hold_ms) begin
      cycle_hold_next = '0;
    end else begin
      cycle_hold_next = cycle_hold;
    end

    // idle stop requests time the drain; a running pump clears it on most paths
    if (!pump_running) begin
      drain_time_next = (!item.upper_full_n || item.store_empty)
                        ? item.now_ms - drain_start_time : drain_time;
    end else if ((!item.upper_full_n && item.store_empty) || (pump_path && !store_fault_next))
    begin
      drain_time_next = '0;
    end else begin
      drain_time_next = drain_time;
    end

    lamps_next = lamps;
    if (!item.upper_full_n) begin
      lamps_next[0] = 1'b1;
    end else if (item.upper_empty) begin
      lamps_next[0] = 1'b0;
    end
    if (!item.upper_empty) begin
      lamps_next[1] = 1'b1;
    end else if (item.upper_full_n) begin
      lamps_next[1] = 1'b0;
    end
    if (!item.store_full) begin
      lamps_next[2] = 1'b0;
    end else if (!item.store_empty) begin
      lamps_next[2] = 1'b1;
    end
    lamps_next[3] = !item.store_empty;

    ev = '0;
    ev[tplc_pkg::EV_UPPER_SET] = upper_fault_next;
    ev[tplc_pkg::EV_UPPER_CLR] = !upper_fault_next && upper_fault_flag;
    ev[tplc_pkg::EV_STORE_SET] = store_fault_next;
    ev[tplc_pkg::EV_STORE_CLR] = !store_fault_next && store_fault_flag;
    ev[tplc_pkg::EV_DISABLED]  = pump_path && store_fault_next;
    ev[tplc_pkg::EV_DRY]       = dry_stop;
    ev[tplc_pkg::EV_CYCLING]   = cycling;
    ev[tplc_pkg::EV_FULL]      = item.store_full && !item.store_empty;
    ev[tplc_pkg::EV_NO_WATER]  = item.store_empty && !last_store_empty;
    ev[tplc_pkg::EV_REFILLED]  = !item.store_empty && last_store_empty;
    ev[tplc_pkg::EV_SETTLE]    = settle;

    // dry stop needs a running pump and settle an idle one, so only one applies
    extra_hold = dry_stop ? cfg.dry_hold_ms : (settle ? cfg.refill_settle_ms : 32'd0);

    // fast poll rate follows the pump state
    poll_s  = pump_running_next ? cfg.fast_poll_seconds : cfg.normal_poll_seconds;
    poll_ms = 18'(poll_s) * 18'(tplc_pkg::MS_PER_S);
    delay   = 34'(poll_ms) + 34'(cycle_hold_next) + 34'(extra_hold);

    res.pump_drive   = pump_running_next;
    res.lamp_bits    = lamps_next;
    res.upper_fault  = upper_fault_next;
    res.store_fault  = store_fault_next;
    res.event_bits   = ev;
    res.next_poll_ms = (delay[33:32] != 2'b00) ? tplc_pkg::DELAY_MAX : delay[31:0];
    res.run_total_ms = run_time_sum_next;
    res.drain_ms     = drain_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_store_empty <= 1'b0;
      upper_fault_flag <= 1'b0;
      store_fault_flag <= 1'b0;
      pump_running     <= 1'b0;
      lamps            <= '0;
      run_start_time   <= '0;
      run_time_sum     <= '0;
      cycle_hold       <= '0;
      drain_start_time <= '0;
      drain_time       <= '0;
    end else if (step) begin
      last_store_empty <= item.store_empty;
      upper_fault_flag <= upper_fault_next;
      store_fault_flag <= store_fault_next;
      pump_running     <= pump_running_next;
      lamps            <= lamps_next;
      run_start_time   <= run_start_time_next;
      run_time_sum     <= run_time_sum_next;
      cycle_hold       <= cycle_hold_next;
      drain_start_time <= drain_start_time_next;
      drain_time       <= drain_time_next;
    end
  end

endmodule

// File: src/tank_pump_level_controller_unit.sv
`timescale 1ns / 1ps

// Tank pump controller: one poll request (four level switches and a millisecond
// timestamp) in, one result out with the pump drive, lamps, fault flags, event
// bits, the delay to the next poll and the run and drain timers. A poll passes
// through an input register and is evaluated combinationally into the result
// register, so a new poll is taken every cycle while the result side keeps up;
// the result register is loaded when the held poll advances. Configuration registers are
// written through the cfg channel, which is always ready, and must only be
// written while no poll is in flight; writes to an unused index are dropped.
module tank_pump_level_controller_unit (
  input logic           clk,
  input logic           rst,
  tplc_poll_if.sink     poll,
  tplc_result_if.source result,
  tplc_cfg_if.sink      cfg
);

  tplc_pkg::cfg_t    cfg_regs;
  tplc_pkg::poll_t   hold_item;
  logic              hold_valid;
  tplc_pkg::result_t res_q;
  logic              res_valid;
  tplc_pkg::result_t core_res;
  logic              advance;

  assign advance    = hold_valid && (!res_valid || result.ready);
  assign poll.ready = !hold_valid || advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= tplc_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tplc_pkg::CFG_NORMAL_POLL:   cfg_regs.normal_poll_seconds <= cfg.data[7:0];
        tplc_pkg::CFG_FAST_POLL:     cfg_regs.fast_poll_seconds   <= cfg.data[7:0];
        tplc_pkg::CFG_DRY_RUN_LIMIT: cfg_regs.dry_run_limit_ms    <= cfg.data;
        tplc_pkg::CFG_DRY_HOLD:      cfg_regs.dry_hold_ms         <= cfg.data;
        tplc_pkg::CFG_SHORT_RUN:     cfg_regs.short_run_ms        <= cfg.data;
        tplc_pkg::CFG_CYCLING_HOLD:  cfg_regs.cycling_hold_ms     <= cfg.data;
        tplc_pkg::CFG_REFILL_SETTLE: cfg_regs.refill_settle_ms    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (poll.valid && poll.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      hold_item.upper_full_n <= poll.upper_full_n;
      hold_item.upper_empty  <= poll.upper_empty;
      hold_item.store_full   <= poll.store_full;
      hold_item.store_empty  <= poll.store_empty;
      hold_item.now_ms       <= poll.now_ms;
    end
  end

  tplc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (hold_item),
    .cfg  (cfg_regs),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign result.valid        = res_valid;
  assign result.pump_drive   = res_q.pump_drive;
  assign result.lamp_bits    = res_q.lamp_bits;
  assign result.upper_fault  = res_q.upper_fault;
  assign result.store_fault  = res_q.store_fault;
  assign result.event_bits   = res_q.event_bits;
  assign result.next_poll_ms = res_q.next_poll_ms;
  assign result.run_total_ms = res_q.run_total_ms;
  assign result.drain_ms     = res_q.drain_ms;

endmodule

// File: src/tplc_checker.sv
`timescale 1ns / 1ps

module tplc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      pump_drive,
  input logic [3:0]                lamp_bits,
  input logic                      upper_fault,
  input logic                      store_fault,
  input logic [tplc_pkg::EV_W-1:0] event_bits,
  input logic [31:0]               next_poll_ms,
  input logic [31:0]               run_total_ms,
  input logic [31:0]               drain_ms
);

  // a stalled result keeps its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pump_drive) && $stable(lamp_bits)
      && $stable(event_bits) && $stable(next_poll_ms) && $stable(run_total_ms)
      && $stable(drain_ms))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // either fault forces a stop request on the same poll
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && (upper_fault || store_fault) |-> !pump_drive)
    else $error("pump on while a fault stands");

  a_stop_events: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_bits[tplc_pkg::EV_DRY] || event_bits[tplc_pkg::EV_CYCLING])
      |-> !pump_drive)
    else $error("pump on after a dry or cycling stop");

  a_settle_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_bits[tplc_pkg::EV_SETTLE] |-> pump_drive && lamp_bits[3]
      && event_bits[tplc_pkg::EV_REFILLED])
    else $error("settle hold without a start after refill");

endmodule

bind tank_pump_level_controller_unit tplc_checker u_tplc_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .pump_drive   (result.pump_drive),
  .lamp_bits    (result.lamp_bits),
  .upper_fault  (result.upper_fault),
  .store_fault  (result.store_fault),
  .event_bits   (result.event_bits),
  .next_poll_ms (result.next_poll_ms),
  .run_total_ms (result.run_total_ms),
  .drain_ms     (result.drain_ms)
);
